>>> sv/assert_macros.svh
// Assertion helpers shared by the frame receiver RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ccfr_pkg.sv
// Types and constants for the checksummed command frame receiver.
// No dependencies; used by ccfr_parser and the top level.
`timescale 1ns / 1ps

package ccfr_pkg;

  localparam int HeaderBytes = 4;
  localparam int MaxLen      = 63;  // length field is 6 bits wide

  // Configuration register indexes
  localparam logic [1:0] CFG_CHECK_ENABLE = 2'd0;
  localparam logic [1:0] CFG_LONG_CMD     = 2'd1;
  localparam logic [1:0] CFG_SHORT_LIMIT  = 2'd2;

  localparam logic [5:0] ShortLimitReset = 6'd10;

  typedef enum logic [2:0] {
    ST_CK_HI,
    ST_CK_LO,
    ST_CMD,
    ST_LEN,
    ST_PAYLOAD
  } state_e;

  typedef struct packed {
    logic       check_enable;
    logic [7:0] long_cmd;
    logic [5:0] short_limit;
  } cfg_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       frame_done;
    logic       frame_ok;
    logic [7:0] frame_command;
    logic [5:0] frame_length;
  } res_t;

endpackage

>>> sv/ccfr_parser.sv
// Frame parser: header/payload state, running sum and per-byte result.
// Depends on ccfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccfr_parser #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  input  ccfr_pkg::cfg_t  cfg_i,
  output ccfr_pkg::res_t  res_o
);

  localparam int LenBoundRaw = BUFFER_BYTES - ccfr_pkg::HeaderBytes;
  localparam int LenBound    = (LenBoundRaw > ccfr_pkg::MaxLen) ? ccfr_pkg::MaxLen
                                                                : LenBoundRaw;
  localparam logic [7:0] LenBoundB = 8'(LenBound);

  ccfr_pkg::state_e state_q, state_d;
  logic [15:0] hdr_sum_q, hdr_sum_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [5:0]  rem_q, rem_d;
  logic [5:0]  len_q, len_d;
  logic [15:0] sum_q, sum_d;

  logic [15:0] sum_add;
  logic [5:0]  len_clamp;
  logic [5:0]  rem_dec;
  logic        done;

  assign sum_add = sum_q + {8'd0, rx_byte_i};
  assign rem_dec = (rem_q != 6'd0) ? rem_q - 6'd1 : 6'd0;

  always_comb begin
    len_clamp = (rx_byte_i > LenBoundB) ? 6'd0 : rx_byte_i[5:0];
    if (cmd_q != cfg_i.long_cmd && len_clamp > cfg_i.short_limit) begin
      len_clamp = 6'd0;
    end
  end

  always_comb begin
    state_d   = state_q;
    hdr_sum_d = hdr_sum_q;
    cmd_d     = cmd_q;
    rem_d     = rem_q;
    len_d     = len_q;
    sum_d     = sum_q;
    res_o     = '0;
    done      = 1'b0;
    unique case (state_q)
      ccfr_pkg::ST_CK_HI: begin
        hdr_sum_d = {rx_byte_i, 8'd0};
        state_d   = ccfr_pkg::ST_CK_LO;
      end
      ccfr_pkg::ST_CK_LO: begin
        hdr_sum_d = {hdr_sum_q[15:8], rx_byte_i};
        state_d   = ccfr_pkg::ST_CMD;
      end
      ccfr_pkg::ST_CMD: begin
        cmd_d   = rx_byte_i;
        sum_d   = {8'd0, rx_byte_i};
        state_d = ccfr_pkg::ST_LEN;
      end
      ccfr_pkg::ST_LEN: begin
        sum_d   = sum_add;
        len_d   = len_clamp;
        rem_d   = len_clamp;
        state_d = ccfr_pkg::ST_PAYLOAD;
        if (len_clamp == 6'd0) begin
          done           = 1'b1;
          res_o.frame_ok = 1'b1;
        end
      end
      ccfr_pkg::ST_PAYLOAD: begin
        sum_d               = sum_add;
        rem_d               = rem_dec;
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = rx_byte_i;
        res_o.payload_index = len_q - rem_q;
        if (rem_dec == 6'd0) begin
          done           = 1'b1;
          res_o.frame_ok = !cfg_i.check_enable || (sum_add == hdr_sum_q);
        end
      end
      default: begin
        state_d = ccfr_pkg::ST_CK_HI;
      end
    endcase
    if (done) begin
      res_o.frame_done    = 1'b1;
      res_o.frame_command = cmd_d;
      res_o.frame_length  = len_d;
      // back to idle
      state_d   = ccfr_pkg::ST_CK_HI;
      hdr_sum_d = '0;
      cmd_d     = '0;
      rem_d     = '0;
      len_d     = '0;
      sum_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ccfr_pkg::ST_CK_HI;
      hdr_sum_q <= '0;
      cmd_q     <= '0;
      rem_q     <= '0;
      len_q     <= '0;
      sum_q     <= '0;
    end else if (accept_i) begin
      state_q   <= state_d;
      hdr_sum_q <= hdr_sum_d;
      cmd_q     <= cmd_d;
      rem_q     <= rem_d;
      len_q     <= len_d;
      sum_q     <= sum_d;
    end
  end

  `ASSERT_IMP(a_payload_rem_nonzero, clk_i, rst_ni,
              state_q == ccfr_pkg::ST_PAYLOAD, rem_q != 6'd0, "payload state with no bytes left")
  `ASSERT_IMP(a_rem_within_len, clk_i, rst_ni,
              1'b1, rem_q <= len_q, "remaining count exceeds frame length")
  `ASSERT_NXT(a_done_to_idle, clk_i, rst_ni,
              accept_i && res_o.frame_done, state_q == ccfr_pkg::ST_CK_HI,
              "parser not idle after frame end")

endmodule

>>> sv/checksummed_command_frame_receiver.sv
// Checksummed command frame receiver, top level: config registers,
// parser instance and output register with skid stage.
// Depends on ccfr_pkg, ccfr_parser and assert_macros.svh.
//
// Usage:
//   Input channel: one received byte per item on rx_byte_i, qualified by
//   in_valid_i and held off by in_stall_o. Frames are checksum high,
//   checksum low, command, length, then payload bytes.
//   Output channel: exactly one result item per input byte, on out_valid_o
//   with out_stall_i from the receiver. Payload bytes carry their index;
//   the byte that ends a frame flags frame_done_o with frame_ok_o, the
//   command and the clamped length.
//   Results are registered, in the output register or, while the receiver
//   stalls, in the skid entry; throughput is one byte per cycle while
//   in_stall_o is low. Config writes (cfg_we_i, cfg_index_i, cfg_data_i)
//   are registered and should only be made while no item is in flight.
//   Reset clears the parser to the start of a frame and loads register
//   defaults (check off, long command 0, short limit 10).
//   When the receiver stalls, the result holds and one more item is taken
//   into a skid stage; in_stall_o rises only once that stage is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module checksummed_command_frame_receiver #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] payload_index_o,
  output logic       frame_done_o,
  output logic       frame_ok_o,
  output logic [7:0] frame_command_o,
  output logic [5:0] frame_length_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  ccfr_pkg::cfg_t cfg_q;
  ccfr_pkg::res_t res;
  ccfr_pkg::res_t out_q, skid_q;
  logic           out_valid_q, skid_valid_q;
  logic           accept, out_take;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_enable <= 1'b0;
      cfg_q.long_cmd     <= 8'd0;
      cfg_q.short_limit  <= ccfr_pkg::ShortLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ccfr_pkg::CFG_CHECK_ENABLE: cfg_q.check_enable <= cfg_data_i[0];
        ccfr_pkg::CFG_LONG_CMD:     cfg_q.long_cmd     <= cfg_data_i;
        ccfr_pkg::CFG_SHORT_LIMIT:  cfg_q.short_limit  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  ccfr_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  // Output register plus one skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = out_q.payload_valid;
  assign payload_byte_o  = out_q.payload_byte;
  assign payload_index_o = out_q.payload_index;
  assign frame_done_o    = out_q.frame_done;
  assign frame_ok_o      = out_q.frame_ok;
  assign frame_command_o = out_q.frame_command;
  assign frame_length_o  = out_q.frame_length;

  `ASSERT_IMP(a_skid_needs_out, clk_i, rst_ni,
              skid_valid_q, out_valid_q, "skid entry filled while output empty")
  `ASSERT_IMP(a_ok_only_on_done, clk_i, rst_ni,
              out_valid_o && !frame_done_o, !frame_ok_o, "frame_ok without frame_done")
  `ASSERT_IMP(a_empty_frame_ok, clk_i, rst_ni,
              out_valid_o && frame_done_o && frame_length_o == 6'd0,
              frame_ok_o && !payload_valid_o, "zero-length frame not accepted")
  `ASSERT_NXT(a_stall_fills_skid, clk_i, rst_ni,
              accept && out_valid_q && out_stall_i && !skid_valid_q, skid_valid_q,
              "item taken under stall did not land in skid")

endmodule

>>> test/ccfr_result_checker.sv
// Result checker for the checksummed command frame receiver: watches both
// channels and the config port, predicts every result item, compares them.
// Depends on ccfr_pkg for the result struct, parser states and register indexes.
`timescale 1ns / 1ps

module ccfr_result_checker #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       payload_valid_i,
  input  logic [7:0] payload_byte_i,
  input  logic [5:0] payload_index_i,
  input  logic       frame_done_i,
  input  logic       frame_ok_i,
  input  logic [7:0] frame_command_i,
  input  logic [5:0] frame_length_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         errors_o,
  output int         outstanding_o,
  output logic       frame_start_o
);

  // length field is 6 bits, so the buffer bound saturates at MaxLen
  localparam int LenRaw   = BUFFER_BYTES - ccfr_pkg::HeaderBytes;
  localparam int LenBound = (LenRaw > ccfr_pkg::MaxLen) ? ccfr_pkg::MaxLen : LenRaw;

  logic              chk_en;
  logic [7:0]        long_cmd;
  logic [5:0]        short_lim;

  ccfr_pkg::state_e  pos;
  logic [15:0]       hdr_sum;
  logic [7:0]        cmd_q;
  logic [5:0]        left;
  logic [5:0]        plen;
  logic [15:0]       acc;

  ccfr_pkg::res_t    parsed_results[$];
  int                err_cnt;

  function void clear_frame();
    pos     = ccfr_pkg::ST_CK_HI;
    hdr_sum = '0;
    cmd_q   = '0;
    left    = '0;
    plen    = '0;
    acc     = '0;
  endfunction

  function void parse_byte(input logic [7:0] b, output ccfr_pkg::res_t r);
    logic [7:0] len;
    logic       done;
    logic       ok;
    r    = '0;
    len  = '0;
    done = 1'b0;
    ok   = 1'b0;
    case (pos)
      ccfr_pkg::ST_CK_HI: begin
        hdr_sum = {b, 8'h00};
        pos     = ccfr_pkg::ST_CK_LO;
      end
      ccfr_pkg::ST_CK_LO: begin
        hdr_sum[7:0] = b;
        pos          = ccfr_pkg::ST_CMD;
      end
      ccfr_pkg::ST_CMD: begin
        cmd_q = b;
        acc   = {8'h00, b};
        pos   = ccfr_pkg::ST_LEN;
      end
      ccfr_pkg::ST_LEN: begin
        // raw length byte is part of the sum even when it gets clamped
        acc = acc + b;
        len = b;
        if (len > LenBound) len = '0;
        if (cmd_q != long_cmd && len > short_lim) len = '0;
        plen = len[5:0];
        left = len[5:0];
        pos  = ccfr_pkg::ST_PAYLOAD;
        if (len == 0) begin
          done = 1'b1;
          ok   = 1'b1;
        end
      end
      default: begin
        acc             = acc + b;
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = plen - left;
        if (left != 0) left = left - 1'b1;
        if (left == 0) begin
          done = 1'b1;
          ok   = !chk_en || (acc == hdr_sum);
        end
      end
    endcase
    if (done) begin
      r.frame_done    = 1'b1;
      r.frame_ok      = ok;
      r.frame_command = cmd_q;
      r.frame_length  = plen;
      clear_frame();
    end
  endfunction

  function void check_field(input string name, input logic [15:0] want,
                            input logic [15:0] seen);
    if (seen !== want) begin
      err_cnt++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ccfr_pkg::res_t want;
    ccfr_pkg::res_t got;
    if (!rst_ni) begin
      chk_en    = 1'b0;
      long_cmd  = '0;
      short_lim = ccfr_pkg::ShortLimitReset;
      clear_frame();
      parsed_results.delete();
      err_cnt   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {payload_valid_i, payload_byte_i, payload_index_i, frame_done_i,
               frame_ok_i, frame_command_i, frame_length_i};
        if (parsed_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result item with nothing expected, got 0x%0h", $time, got);
        end else begin
          want = parsed_results.pop_front();
          check_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
          check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
          check_field("payload_index", 16'(want.payload_index), 16'(got.payload_index));
          check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
          check_field("frame_ok", 16'(want.frame_ok), 16'(got.frame_ok));
          check_field("frame_command", 16'(want.frame_command), 16'(got.frame_command));
          check_field("frame_length", 16'(want.frame_length), 16'(got.frame_length));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          ccfr_pkg::CFG_CHECK_ENABLE: chk_en    = cfg_data_i[0];
          ccfr_pkg::CFG_LONG_CMD:     long_cmd  = cfg_data_i;
          ccfr_pkg::CFG_SHORT_LIMIT:  short_lim = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(rx_byte_i, want);
        parsed_results.push_back(want);
      end
    end
    errors_o      <= err_cnt;
    outstanding_o <= parsed_results.size();
    frame_start_o <= (pos == ccfr_pkg::ST_CK_HI);
  end

endmodule

>>> test/tb_checksummed_command_frame_receiver.sv
// Testbench top for the checksummed command frame receiver: clock, reset,
// frame stimulus, receiver stalls and the verdict.
// Depends on ccfr_pkg, the block and ccfr_result_checker.
`timescale 1ns / 1ps

module tb_checksummed_command_frame_receiver;

  localparam int         BufBytes   = 64;
  localparam int         LenCap     = BufBytes - ccfr_pkg::HeaderBytes;
  localparam logic [1:0] CfgSpare   = 2'd3;  // no register behind this index
  localparam int         PhaseBytes = 300;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic       frame_done;
  logic       frame_ok;
  logic [7:0] frame_command;
  logic [5:0] frame_length;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int         errors;
  int         outstanding;
  logic       frame_start;

  int         send_idle_pct;
  int         recv_idle_pct;
  int         sent_cnt;
  logic [7:0] cur_long;
  logic [5:0] cur_short;

  checksummed_command_frame_receiver #(
    .BUFFER_BYTES(BufBytes)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .payload_valid_o(payload_valid),
    .payload_byte_o (payload_byte),
    .payload_index_o(payload_index),
    .frame_done_o   (frame_done),
    .frame_ok_o     (frame_ok),
    .frame_command_o(frame_command),
    .frame_length_o (frame_length),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  ccfr_result_checker #(
    .BUFFER_BYTES(BufBytes)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .payload_valid_i(payload_valid),
    .payload_byte_i (payload_byte),
    .payload_index_i(payload_index),
    .frame_done_i   (frame_done),
    .frame_ok_i     (frame_ok),
    .frame_command_i(frame_command),
    .frame_length_i (frame_length),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .errors_o       (errors),
    .outstanding_o  (outstanding),
    .frame_start_o  (frame_start)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_checksummed_command_frame_receiver: errors");
    $finish;
  end

  // valid stays high from one item to the next unless the sender idles
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // feed zeros until the parser is back at a frame start
  task automatic resync();
    settle();
    while (!frame_start) begin
      send_byte(8'h00);
      settle();
    end
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input int n_body, input bit bad);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] sum;
    sum = 16'(cmd) + 16'(len);
    repeat (n_body) begin
      b = 8'($urandom);
      body.push_back(b);
      sum = sum + b;
    end
    if (bad) sum = sum ^ 16'($urandom_range(1, 65535));
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
    send_byte(cmd);
    send_byte(len);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ccfr_pkg::CFG_LONG_CMD:    cur_long  = data;
      ccfr_pkg::CFG_SHORT_LIMIT: cur_short = data[5:0];
      default: ;
    endcase
  endtask

  // unused upper data bits are filled with noise
  task automatic apply_setting(input logic chk, input logic [7:0] lng,
                               input logic [5:0] sht);
    logic [7:0] rnd;
    settle();
    rnd = 8'($urandom);
    set_reg(ccfr_pkg::CFG_CHECK_ENABLE, {rnd[7:1], chk});
    set_reg(ccfr_pkg::CFG_LONG_CMD, lng);
    set_reg(ccfr_pkg::CFG_SHORT_LIMIT, {rnd[1:0], sht});
  endtask

  initial begin : result_sink
    int taken;
    int hold;
    bit held;
    taken     = 0;
    hold      = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      // one long hold-off so the skid stage fills and the input stalls
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!held && taken >= 300) begin
        held      = 1'b1;
        hold      = 200;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int         ph;
    int         phase_start;
    int         pick;
    int         cap;
    int         len;
    int         n;
    int         guard;
    logic [7:0] cmd;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    rx_byte       = '0;
    cfg_we        = 1'b0;
    cfg_index     = ccfr_pkg::CFG_CHECK_ENABLE;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_cnt      = 0;
    cur_long      = '0;
    cur_short     = ccfr_pkg::ShortLimitReset;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero length done at once, over short limit clamped
    send_frame(8'h00, 8'd0, 0, 1'b1);
    send_frame(8'h5A, 8'd11, 0, 1'b0);
    apply_setting(1'b1, 8'hFF, 6'd2);
    set_reg(CfgSpare, 8'hC3);
    send_frame(8'hFF, 8'd5, 5, 1'b0);   // long command past the short limit
    send_frame(8'h01, 8'd2, 2, 1'b1);   // checksum error
    send_frame(8'hFF, 8'hFF, 0, 1'b0);  // past the buffer bound

    for (ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0:       apply_setting(1'b1, 8'hFF, 6'd0);
        1:       apply_setting(1'b0, 8'h00, 6'd60);
        2:       apply_setting(1'b1, 8'($urandom), 6'($urandom_range(0, 60)));
        3:       apply_setting(1'b1, 8'h00, 6'd63);
        4:       apply_setting(1'b0, 8'($urandom), 6'($urandom_range(0, 60)));
        default: apply_setting(1'b1, 8'hA5, ccfr_pkg::ShortLimitReset);
      endcase
      if (ph == 0) send_frame(cur_long, 8'(LenCap), LenCap, 1'b0);  // fills the buffer
      phase_start = sent_cnt;
      while (sent_cnt - phase_start < PhaseBytes) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          cmd = ($urandom_range(0, 9) < 3) ? cur_long : 8'($urandom);
          cap = (cmd == cur_long || cur_short > LenCap) ? LenCap : cur_short;
          n   = $urandom_range(0, 9);
          if (n == 0) len = cap;
          else if (n < 3) len = $urandom_range(0, cap);
          else len = $urandom_range(0, (cap < 8) ? cap : 8);
          send_frame(cmd, 8'(len), len, $urandom_range(0, 9) == 0);
        end else if (pick < 90) begin
          // broken frame: arbitrary header, body short, missing or too long
          send_frame(8'($urandom), 8'($urandom), $urandom_range(0, 8), 1'($urandom));
          resync();
        end else begin
          repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
          resync();
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_checksummed_command_frame_receiver: clean");
    end else begin
      $display("tb_checksummed_command_frame_receiver: errors");
    end
    $finish;
  end

endmodule

>>> checksummed_command_frame_receiver.f
+incdir+sv
sv/ccfr_pkg.sv
sv/ccfr_parser.sv
sv/checksummed_command_frame_receiver.sv
test/ccfr_result_checker.sv
test/tb_checksummed_command_frame_receiver.sv
